>>> rtl/core/occupancy_cell_fusion_unit_defines.svh
// Assertion macros for the occupancy cell fusion unit.
`ifndef OCCUPANCY_CELL_FUSION_UNIT_DEFINES_SVH
`define OCCUPANCY_CELL_FUSION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define OCCF_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("occf assertion failed");
`define OCCF_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("occf assertion failed");
`else
`define OCCF_ASSERT_RST(lbl, clk, rst_n, prop)
`define OCCF_ASSERT(lbl, clk, prop)
`endif

`endif

>>> rtl/core/occf_pkg.sv
// Shared types, constants and register indexes of the occupancy cell fusion unit.
package occf_pkg;

    localparam int unsigned MaxCellsDefault = 1048576;

    localparam int unsigned ThrW    = 7;
    localparam int unsigned SlopeW  = 15;
    localparam int unsigned RhsW    = 22;
    localparam int unsigned ValW    = 8;
    localparam int unsigned CountW  = 21;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgW    = 15;

    localparam logic [ThrW-1:0]   ThrMax           = 7'd100;
    localparam logic [ThrW-1:0]   StaticThrReset   = 7'd65;
    localparam logic [ThrW-1:0]   TerrainThrReset  = 7'd65;
    localparam logic [SlopeW-1:0] SlopeScaleReset  = 15'd11520;
    localparam logic [SlopeW-1:0] SlopeLimitReset  = 15'd7680;
    localparam logic [RhsW-1:0]   SlopeRhsReset    = 22'd768000;
    localparam logic [ValW-1:0]   CellOccupied     = 8'd100;
    localparam logic [ValW-1:0]   CellUnknown      = 8'hFF;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_STATIC_THR   = 3'd0,
        CFG_TERRAIN_THR  = 3'd1,
        CFG_SLOPE_SCALE  = 3'd2,
        CFG_SLOPE_LIMIT  = 3'd3,
        CFG_UNKNOWN_OBST = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_UNKNOWN  = 2'd0,
        CLS_OCCUPIED = 2'd1,
        CLS_FREE     = 2'd2
    } t_cls;

    typedef struct packed {
        logic [ThrW-1:0]   static_thr;
        logic [ThrW-1:0]   terrain_thr;
        logic [SlopeW-1:0] slp_scale;
        logic [RhsW-1:0]   slope_rhs;
        logic              unknown_as_obstacle;
    } t_cfg;

    typedef struct packed {
        logic            first_of_map;
        logic [ValW-1:0] stat_val;
        logic            static_present;
        logic [ValW-1:0] rog_val;
        logic            rog_present;
        logic [ValW-1:0] terr_val;
        logic            terrain_present;
        logic [ValW-1:0] slp_val;
        logic            slope_present;
        logic            last_of_cell;
    } t_item;

    typedef struct packed {
        logic            occupied;
        logic            seen_free;
        logic [ThrW-1:0] run_max;
    } t_acc;

    typedef struct packed {
        logic [ValW-1:0] value;
        t_cls            cls;
    } t_cell;

endpackage

>>> rtl/core/occf_cfg.sv
// Configuration registers with threshold clamping and the precomputed slope bound.
module occf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [occf_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [occf_pkg::CfgW-1:0]     i_cfg_data,
    output occf_pkg::t_cfg                o_cfg
);

    logic [occf_pkg::ThrW-1:0]   r_static_thr;
    logic [occf_pkg::ThrW-1:0]   r_terrain_thr;
    logic [occf_pkg::SlopeW-1:0] r_slope_scale;
    logic [occf_pkg::RhsW-1:0]   r_slope_rhs;
    logic                        r_unknown_obst;
    logic [occf_pkg::RhsW-1:0]   n_slope_rhs;

    // 100 * limit = 64x + 32x + 4x
    assign n_slope_rhs = ({7'd0, i_cfg_data} << 6) + ({7'd0, i_cfg_data} << 5)
                       + ({7'd0, i_cfg_data} << 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_static_thr   <= occf_pkg::StaticThrReset;
            r_terrain_thr  <= occf_pkg::TerrainThrReset;
            r_slope_scale  <= occf_pkg::SlopeScaleReset;
            r_slope_rhs    <= occf_pkg::SlopeRhsReset;
            r_unknown_obst <= 1'b0;
        end else if (i_cfg_we) begin
            case (occf_pkg::t_cfg_idx'(i_cfg_idx))
                occf_pkg::CFG_STATIC_THR: begin
                    r_static_thr <= i_cfg_data[occf_pkg::ThrW-1:0];
                end
                occf_pkg::CFG_TERRAIN_THR: begin
                    r_terrain_thr <= i_cfg_data[occf_pkg::ThrW-1:0];
                end
                occf_pkg::CFG_SLOPE_SCALE: begin
                    r_slope_scale <= i_cfg_data;
                end
                occf_pkg::CFG_SLOPE_LIMIT: begin
                    r_slope_rhs <= n_slope_rhs;
                end
                occf_pkg::CFG_UNKNOWN_OBST: begin
                    r_unknown_obst <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.static_thr  = (r_static_thr > occf_pkg::ThrMax) ? occf_pkg::ThrMax
                                                              : r_static_thr;
        o_cfg.terrain_thr = (r_terrain_thr > occf_pkg::ThrMax) ? occf_pkg::ThrMax
                                                               : r_terrain_thr;
        o_cfg.slp_scale   = r_slope_scale;
        o_cfg.slope_rhs   = r_slope_rhs;
        o_cfg.unknown_as_obstacle = r_unknown_obst;
    end

endmodule

>>> rtl/core/occf_eval.sv
// Per-item evaluation: source compares, max accumulation and cell classification.
module occf_eval (
    input  occf_pkg::t_cfg  i_cfg,
    input  occf_pkg::t_item i_item,
    input  occf_pkg::t_acc  i_acc,
    output occf_pkg::t_acc  o_acc,
    output occf_pkg::t_cell o_cell
);

    logic signed [8:0]  s_sthr;
    logic signed [8:0]  s_tthr;
    logic signed [8:0]  s_static;
    logic signed [8:0]  s_rog;
    logic signed [8:0]  s_terr;
    logic signed [23:0] s_slope_prod;
    logic signed [23:0] s_slope_rhs;
    logic               s_slope_hit;
    logic               s_use_rog;
    logic               s_use_terr;
    logic               s_use_slope;
    occf_pkg::t_acc     s_acc;
    logic signed [8:0]  s_val9;

    always_comb begin
        s_sthr   = $signed({2'b00, i_cfg.static_thr});
        s_tthr   = $signed({2'b00, i_cfg.terrain_thr});
        s_static = $signed({i_item.stat_val[7], i_item.stat_val});
        s_rog    = $signed({i_item.rog_val[7], i_item.rog_val});
        s_terr   = $signed({i_item.terr_val[7], i_item.terr_val});

        s_use_rog   = i_item.last_of_cell && i_item.rog_present;
        s_use_terr  = i_item.last_of_cell && i_item.terrain_present;
        s_use_slope = i_item.last_of_cell && i_item.slope_present;

        s_slope_prod = $signed(i_item.slp_val) * $signed({1'b0, i_cfg.slp_scale});
        s_slope_rhs  = $signed({2'b00, i_cfg.slope_rhs});
        if (i_cfg.slp_scale == '0) begin
            s_slope_hit = !i_item.slp_val[7] && (i_cfg.slope_rhs == '0);
        end else begin
            s_slope_hit = s_slope_prod >= s_slope_rhs;
        end

        s_acc = i_acc;
        if (i_item.static_present) begin
            if (s_static >= s_sthr) begin
                s_acc.occupied = 1'b1;
            end else if (!s_static[8]) begin
                s_acc.seen_free = 1'b1;
                if (s_static[6:0] > s_acc.run_max) s_acc.run_max = s_static[6:0];
            end
        end
        if (s_use_rog) begin
            if (s_rog >= s_tthr) begin
                s_acc.occupied = 1'b1;
            end else if (!s_rog[8]) begin
                s_acc.seen_free = 1'b1;
                if (s_rog[6:0] > s_acc.run_max) s_acc.run_max = s_rog[6:0];
            end
        end
        if (s_use_terr) begin
            if (s_terr >= s_tthr) begin
                s_acc.occupied = 1'b1;
            end else if (!s_terr[8]) begin
                s_acc.seen_free = 1'b1;
                if (s_terr[6:0] > s_acc.run_max) s_acc.run_max = s_terr[6:0];
            end
        end
        if (s_use_slope) begin
            if (s_slope_hit) begin
                s_acc.occupied = 1'b1;
            end else if (!i_item.slp_val[7]) begin
                s_acc.seen_free = 1'b1;
            end
        end
        o_acc = s_acc;

        if (s_acc.occupied) begin
            o_cell.value = occf_pkg::CellOccupied;
        end else if (i_cfg.unknown_as_obstacle && !s_acc.seen_free) begin
            o_cell.value = occf_pkg::CellUnknown;
        end else begin
            o_cell.value = {1'b0, s_acc.run_max};
        end

        s_val9 = $signed({o_cell.value[7], o_cell.value});
        if (s_val9[8]) begin
            o_cell.cls = occf_pkg::CLS_UNKNOWN;
        end else if (s_val9 >= s_tthr) begin
            o_cell.cls = occf_pkg::CLS_OCCUPIED;
        end else begin
            o_cell.cls = occf_pkg::CLS_FREE;
        end
    end

endmodule

>>> rtl/core/occupancy_cell_fusion_unit.sv
// Top level of the occupancy cell fusion unit.
// Fuses a stream of footprint items into planning cells. An item is registered on
// acceptance and evaluated in the following cycle; an item flagged last_of_cell
// lands in the result register together with its counts; other items update the
// cell accumulator and clear the counts on first_of_map. One item is taken per
// clock; the input side stalls only while a finished result waits in the result
// register and the next registered item also ends a cell. Result valid rises
// when the registered last item of a cell moves into the result register. The
// slope check uses one 8x16 multiply against a bound of 100 * slope_limit that is
// formed when slope_limit is written. Running counts saturate at MAX_CELLS and show
// their low 21 bits. Configuration may be written only while the block is idle.
`include "occupancy_cell_fusion_unit_defines.svh"

module occupancy_cell_fusion_unit #(
    parameter int unsigned MAX_CELLS = occf_pkg::MaxCellsDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [occf_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [occf_pkg::CfgW-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_first_of_map,
    input  logic signed [7:0]                 i_static_value,
    input  logic                              i_static_present,
    input  logic signed [7:0]                 i_rog_value,
    input  logic                              i_rog_present,
    input  logic signed [7:0]                 i_terrain_value,
    input  logic                              i_terrain_present,
    input  logic signed [7:0]                 i_slope_value,
    input  logic                              i_slope_present,
    input  logic                              i_last_of_cell,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [7:0]                 o_cell_value,
    output logic [occf_pkg::CountW-1:0]       o_unknown_count,
    output logic [occf_pkg::CountW-1:0]       o_occupied_count,
    output logic [occf_pkg::CountW-1:0]       o_free_count
);

    localparam int unsigned CntW = $clog2(MAX_CELLS + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_CELLS);

    occf_pkg::t_cfg  cfg;
    occf_pkg::t_acc  acc_next;
    occf_pkg::t_cell fused;

    logic            r_in_valid;
    occf_pkg::t_item r_in;
    occf_pkg::t_acc  r_acc;
    logic            r_out_valid;
    logic [occf_pkg::ValW-1:0] r_out_value;
    logic [occf_pkg::CountW-1:0] r_out_unk;
    logic [occf_pkg::CountW-1:0] r_out_occ;
    logic [occf_pkg::CountW-1:0] r_out_free;
    logic [CntW-1:0] r_unk_cnt;
    logic [CntW-1:0] r_occ_cnt;
    logic [CntW-1:0] r_free_cnt;
    logic [CntW-1:0] n_unk_cnt;
    logic [CntW-1:0] n_occ_cnt;
    logic [CntW-1:0] n_free_cnt;
    logic            advance;
    logic            out_free;
    logic            held_last;
    logic            out_unknown;
    logic [CntW+occf_pkg::CountW-1:0] unk_ext;
    logic [CntW+occf_pkg::CountW-1:0] occ_ext;
    logic [CntW+occf_pkg::CountW-1:0] free_ext;

    occf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    occf_eval u_eval (
        .i_cfg  (cfg),
        .i_item (r_in),
        .i_acc  (r_acc),
        .o_acc  (acc_next),
        .o_cell (fused)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_in.last_of_cell || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        n_unk_cnt  = r_in.first_of_map ? '0 : r_unk_cnt;
        n_occ_cnt  = r_in.first_of_map ? '0 : r_occ_cnt;
        n_free_cnt = r_in.first_of_map ? '0 : r_free_cnt;
        if (r_in.last_of_cell) begin
            case (fused.cls)
                occf_pkg::CLS_UNKNOWN: begin
                    if (n_unk_cnt < CntMax) n_unk_cnt = n_unk_cnt + 1'b1;
                end
                occf_pkg::CLS_OCCUPIED: begin
                    if (n_occ_cnt < CntMax) n_occ_cnt = n_occ_cnt + 1'b1;
                end
                default: begin
                    if (n_free_cnt < CntMax) n_free_cnt = n_free_cnt + 1'b1;
                end
            endcase
        end
    end

    // Hold the registered item until it can advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.first_of_map    <= i_first_of_map;
            r_in.stat_val        <= i_static_value;
            r_in.static_present  <= i_static_present;
            r_in.rog_val         <= i_rog_value;
            r_in.rog_present     <= i_rog_present;
            r_in.terr_val        <= i_terrain_value;
            r_in.terrain_present <= i_terrain_present;
            r_in.slp_val         <= i_slope_value;
            r_in.slope_present   <= i_slope_present;
            r_in.last_of_cell    <= i_last_of_cell;
        end
    end

    // Accumulate the cell and the running counts; clear the cell after its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_unk_cnt  <= '0;
            r_occ_cnt  <= '0;
            r_free_cnt <= '0;
        end else if (advance) begin
            r_acc      <= r_in.last_of_cell ? '0 : acc_next;
            r_unk_cnt  <= n_unk_cnt;
            r_occ_cnt  <= n_occ_cnt;
            r_free_cnt <= n_free_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && r_in.last_of_cell;
        end
    end

    assign unk_ext  = {{occf_pkg::CountW{1'b0}}, n_unk_cnt};
    assign occ_ext  = {{occf_pkg::CountW{1'b0}}, n_occ_cnt};
    assign free_ext = {{occf_pkg::CountW{1'b0}}, n_free_cnt};

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last_of_cell) begin
            r_out_value <= fused.value;
            r_out_unk   <= unk_ext[occf_pkg::CountW-1:0];
            r_out_occ   <= occ_ext[occf_pkg::CountW-1:0];
            r_out_free  <= free_ext[occf_pkg::CountW-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cell_value     = $signed(r_out_value);
    assign o_unknown_count  = r_out_unk;
    assign o_occupied_count = r_out_occ;
    assign o_free_count     = r_out_free;

    assign held_last   = r_in_valid && r_in.last_of_cell;
    assign out_unknown = r_out_valid && (r_out_value == occf_pkg::CellUnknown);

    `OCCF_ASSERT_RST(a_stall_cause, i_clk, i_rst_n, !o_in_ready |-> (held_last && !out_free))
    `OCCF_ASSERT_RST(a_max_below_occ, i_clk, i_rst_n, r_acc.run_max < occf_pkg::ThrMax)
    `OCCF_ASSERT_RST(a_max_needs_free, i_clk, i_rst_n, (r_acc.run_max != '0) |-> r_acc.seen_free)
    `OCCF_ASSERT_RST(a_unknown_counted, i_clk, i_rst_n, out_unknown |-> (r_out_unk != '0))
    `OCCF_ASSERT_RST(a_hold, i_clk, i_rst_n, !out_free |=> (r_out_valid && $stable(r_out_value)))

endmodule

>>> bench/occupancy_cell_fusion_checker.sv
// Checker for the occupancy cell fusion unit: predicts fused cells and compares them.
`timescale 1ns / 100ps

module occupancy_cell_fusion_checker #(
    parameter int unsigned MAX_CELLS = occf_pkg::MaxCellsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [occf_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [occf_pkg::CfgW-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_first_of_map,
    input  logic [7:0]                   i_static_value,
    input  logic                         i_static_present,
    input  logic [7:0]                   i_rog_value,
    input  logic                         i_rog_present,
    input  logic [7:0]                   i_terrain_value,
    input  logic                         i_terrain_present,
    input  logic [7:0]                   i_slope_value,
    input  logic                         i_slope_present,
    input  logic                         i_last_of_cell,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [7:0]                   i_cell_value,
    input  logic [occf_pkg::CountW-1:0]  i_unknown_count,
    input  logic [occf_pkg::CountW-1:0]  i_occupied_count,
    input  logic [occf_pkg::CountW-1:0]  i_free_count,
    output int                           o_fail_count,
    output int                           o_pending
);
    import occf_pkg::*;

    typedef struct packed {
        logic [ValW-1:0]   cell_value;
        logic [CountW-1:0] unknown_count;
        logic [CountW-1:0] occupied_count;
        logic [CountW-1:0] free_count;
    } t_fused;

    t_fused            fused_q[$];
    int                fail_total = 0;
    int                pend_n = 0;
    int                cells_seen = 0;

    logic [ThrW-1:0]   thr_static;
    logic [ThrW-1:0]   thr_terrain;
    logic [SlopeW-1:0] scale_reg;
    logic [SlopeW-1:0] limit_reg;
    logic              unk_obst;
    bit                occ_flag;
    bit                free_flag;
    int                run_max;
    logic [CountW-1:0] unk_total;
    logic [CountW-1:0] occ_total;
    logic [CountW-1:0] free_total;

    assign o_fail_count = fail_total;
    assign o_pending    = pend_n;

    function automatic int clamp_thr(logic [ThrW-1:0] t);
        return (t > ThrMax) ? int'(ThrMax) : int'(t);
    endfunction

    function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] c);
        return (c < MAX_CELLS) ? c + 1'b1 : c;
    endfunction

    task automatic report(string what);
        fail_total++;
        if (fail_total <= 100) $display("ERROR: cell %0d: %s", cells_seen, what);
    endtask

    task automatic mark_value(int v, int thr);
        if (v >= thr) begin
            occ_flag = 1'b1;
        end else if (v >= 0) begin
            free_flag = 1'b1;
            if (v > run_max) run_max = v;
        end
    endtask

    task automatic clear_model();
        thr_static  = StaticThrReset;
        thr_terrain = TerrainThrReset;
        scale_reg   = SlopeScaleReset;
        limit_reg   = SlopeLimitReset;
        unk_obst    = 1'b0;
        occ_flag    = 1'b0;
        free_flag   = 1'b0;
        run_max     = 0;
        unk_total   = '0;
        occ_total   = '0;
        free_total  = '0;
        fused_q.delete();
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CfgW-1:0] data);
        case (idx)
            CFG_STATIC_THR:   thr_static  = data[ThrW-1:0];
            CFG_TERRAIN_THR:  thr_terrain = data[ThrW-1:0];
            CFG_SLOPE_SCALE:  scale_reg   = data[SlopeW-1:0];
            CFG_SLOPE_LIMIT:  limit_reg   = data[SlopeW-1:0];
            CFG_UNKNOWN_OBST: unk_obst    = data[0];
            default: ;
        endcase
    endtask

    task automatic fuse_item(t_item it);
        int          sthr;
        int          tthr;
        int          sv;
        int          value;
        longint      lhs;
        longint      rhs;
        longint      sc;
        longint      lim;
        bit          hit;
        t_fused      res;
        sthr = clamp_thr(thr_static);
        tthr = clamp_thr(thr_terrain);
        if (it.first_of_map) begin
            unk_total  = '0;
            occ_total  = '0;
            free_total = '0;
        end
        if (it.static_present) begin
            sv = $signed(it.stat_val);
            mark_value(sv, sthr);
        end
        if (!it.last_of_cell) return;
        if (it.rog_present) begin
            sv = $signed(it.rog_val);
            mark_value(sv, tthr);
        end
        if (it.terrain_present) begin
            sv = $signed(it.terr_val);
            mark_value(sv, tthr);
        end
        if (it.slope_present) begin
            sv  = $signed(it.slp_val);
            sc  = scale_reg;
            lim = limit_reg;
            lhs = sv * sc;
            rhs = 100 * lim;
            if (scale_reg == 0) hit = (sv >= 0) && (limit_reg == 0);
            else hit = (lhs >= rhs);
            if (hit) occ_flag = 1'b1;
            else if (sv >= 0) free_flag = 1'b1;
        end
        if (occ_flag) value = 100;
        else if (unk_obst && !free_flag) value = -1;
        else value = run_max;
        if (value < 0) unk_total = sat_inc(unk_total);
        else if (value >= tthr) occ_total = sat_inc(occ_total);
        else free_total = sat_inc(free_total);
        res.cell_value     = value[7:0];
        res.unknown_count  = unk_total;
        res.occupied_count = occ_total;
        res.free_count     = free_total;
        fused_q.push_back(res);
        occ_flag  = 1'b0;
        free_flag = 1'b0;
        run_max   = 0;
    endtask

    task automatic compare_result();
        t_fused want;
        if (fused_q.size() == 0) begin
            report("result with no cell pending");
            return;
        end
        want = fused_q.pop_front();
        if (i_cell_value !== want.cell_value)
            report($sformatf("cell_value %0d, expected %0d",
                             $signed(i_cell_value), $signed(want.cell_value)));
        if (i_unknown_count !== want.unknown_count)
            report($sformatf("unknown_count %0d, expected %0d",
                             i_unknown_count, want.unknown_count));
        if (i_occupied_count !== want.occupied_count)
            report($sformatf("occupied_count %0d, expected %0d",
                             i_occupied_count, want.occupied_count));
        if (i_free_count !== want.free_count)
            report($sformatf("free_count %0d, expected %0d",
                             i_free_count, want.free_count));
        cells_seen++;
    endtask

    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_out_valid && i_out_ready) compare_result();
            if (i_cfg_we) write_reg(t_cfg_idx'(i_cfg_idx), i_cfg_data);
            if (i_in_valid && i_in_ready) begin
                it.first_of_map    = i_first_of_map;
                it.stat_val        = i_static_value;
                it.static_present  = i_static_present;
                it.rog_val         = i_rog_value;
                it.rog_present     = i_rog_present;
                it.terr_val        = i_terrain_value;
                it.terrain_present = i_terrain_present;
                it.slp_val         = i_slope_value;
                it.slope_present   = i_slope_present;
                it.last_of_cell    = i_last_of_cell;
                fuse_item(it);
            end
        end
        pend_n = fused_q.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the occupancy cell fusion testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import occf_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgW-1:0]     i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_first_of_map = 1'b0;
    logic signed [7:0]   i_static_value = '0;
    logic                i_static_present = 1'b0;
    logic signed [7:0]   i_rog_value = '0;
    logic                i_rog_present = 1'b0;
    logic signed [7:0]   i_terrain_value = '0;
    logic                i_terrain_present = 1'b0;
    logic signed [7:0]   i_slope_value = '0;
    logic                i_slope_present = 1'b0;
    logic                i_last_of_cell = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic signed [7:0]   o_cell_value;
    logic [CountW-1:0]   o_unknown_count;
    logic [CountW-1:0]   o_occupied_count;
    logic [CountW-1:0]   o_free_count;

    int                  fail_count;
    int                  pending;
    bit                  tx_calm = 1'b0;
    bit                  rx_calm = 1'b0;
    int                  cur_sthr = StaticThrReset;
    int                  cur_tthr = TerrainThrReset;

    always #6 i_clk = ~i_clk;

    occupancy_cell_fusion_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_first_of_map    (i_first_of_map),
        .i_static_value    (i_static_value),
        .i_static_present  (i_static_present),
        .i_rog_value       (i_rog_value),
        .i_rog_present     (i_rog_present),
        .i_terrain_value   (i_terrain_value),
        .i_terrain_present (i_terrain_present),
        .i_slope_value     (i_slope_value),
        .i_slope_present   (i_slope_present),
        .i_last_of_cell    (i_last_of_cell),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_cell_value      (o_cell_value),
        .o_unknown_count   (o_unknown_count),
        .o_occupied_count  (o_occupied_count),
        .o_free_count      (o_free_count)
    );

    occupancy_cell_fusion_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_first_of_map    (i_first_of_map),
        .i_static_value    (i_static_value),
        .i_static_present  (i_static_present),
        .i_rog_value       (i_rog_value),
        .i_rog_present     (i_rog_present),
        .i_terrain_value   (i_terrain_value),
        .i_terrain_present (i_terrain_present),
        .i_slope_value     (i_slope_value),
        .i_slope_present   (i_slope_present),
        .i_last_of_cell    (i_last_of_cell),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_cell_value      (o_cell_value),
        .i_unknown_count   (o_unknown_count),
        .i_occupied_count  (o_occupied_count),
        .i_free_count      (o_free_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    function automatic int draw_gap(bit calm);
        if (calm || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic t_item mk(bit first, int sv, bit sp, int rv, bit rp,
                                 int tv, bit tp, int slv, bit slp, bit last);
        t_item it;
        it.first_of_map    = first;
        it.stat_val        = sv[7:0];
        it.static_present  = sp;
        it.rog_val         = rv[7:0];
        it.rog_present     = rp;
        it.terr_val        = tv[7:0];
        it.terrain_present = tp;
        it.slp_val         = slv[7:0];
        it.slope_present   = slp;
        it.last_of_cell    = last;
        return it;
    endfunction

    function automatic int pick_value(int thr);
        int t;
        t = (thr > 100) ? 100 : thr;
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255);
            1: return $urandom_range(128, 255);
            2: return t + int'($urandom_range(0, 2)) - 1;
            3: return ($urandom_range(0, 1) != 0) ? 100 : 0;
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    function automatic t_item rand_item(bit last);
        return mk($urandom_range(0, 39) == 0,
                  pick_value(cur_sthr), $urandom_range(0, 4) != 0,
                  pick_value(cur_tthr), $urandom_range(0, 3) != 0,
                  pick_value(cur_tthr), $urandom_range(0, 3) != 0,
                  $urandom_range(0, 255), $urandom_range(0, 2) != 0,
                  last);
    endfunction

    task automatic send_item(t_item it);
        int gap;
        gap = draw_gap(tx_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_first_of_map    = it.first_of_map;
        i_static_value    = it.stat_val;
        i_static_present  = it.static_present;
        i_rog_value       = it.rog_val;
        i_rog_present     = it.rog_present;
        i_terrain_value   = it.terr_val;
        i_terrain_present = it.terrain_present;
        i_slope_value     = it.slp_val;
        i_slope_present   = it.slope_present;
        i_last_of_cell    = it.last_of_cell;
        i_in_valid        = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // hold off until every pending cell is out and the pipeline has drained
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, int data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data[CfgW-1:0];
    endtask

    task automatic set_config(int sthr, int tthr, int scale, int limit, bit unk);
        wait_idle();
        cfg_write(CFG_STATIC_THR, sthr);
        cfg_write(CFG_TERRAIN_THR, tthr);
        cfg_write(CFG_SLOPE_SCALE, scale);
        cfg_write(CFG_SLOPE_LIMIT, limit);
        cfg_write(CFG_UNKNOWN_OBST, unk);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cur_sthr = sthr;
        cur_tthr = tthr;
    endtask

    task automatic run_cells(int n_items, bit drain_midway);
        int sent;
        int len;
        bit drained;
        sent    = 0;
        drained = 1'b0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 3);
            for (int j = 0; j < len; j++) begin
                send_item(rand_item(j == len - 1));
                sent++;
            end
            if (drain_midway && !drained && sent >= n_items / 2) begin
                wait_idle();
                drained = 1'b1;
            end
        end
    endtask

    initial begin
        int gap;
        forever begin
            gap = draw_gap(rx_calm);
            @(negedge i_clk);
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: 65 / 65, slope hit from raw 67 upward
        send_item(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        send_item(mk(0, 127, 1, 0, 0, 0, 0, 0, 0, 1));
        send_item(mk(0, -128, 1, 0, 0, 0, 0, 0, 0, 1));
        send_item(mk(0, 64, 1, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(0, -1, 1, 64, 1, -128, 1, -128, 1, 1));
        send_item(mk(0, 65, 1, 0, 0, 0, 0, 0, 0, 1));
        send_item(mk(0, 0, 0, 127, 1, 0, 0, 0, 0, 1));
        send_item(mk(0, 0, 0, 0, 1, 65, 1, 0, 0, 1));
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 66, 1, 1));
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 67, 1, 1));
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 127, 1, 1));
        send_item(mk(1, 10, 1, 0, 0, 0, 0, 0, 0, 1));

        // clamped thresholds, zero slope scale and zero limit, unknown as obstacle
        set_config(127, 101, 0, 0, 1);
        send_item(mk(0, 100, 1, 0, 0, 0, 0, 0, 0, 1));
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        send_item(mk(0, 0, 0, 0, 0, 0, 0, -1, 1, 1));
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        send_item(mk(0, 0, 0, 127, 1, 99, 1, 0, 0, 1));
        send_item(mk(1, -5, 1, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(0, 99, 1, 0, 0, 0, 0, 0, 0, 1));
        set_config(127, 101, 0, 1, 1);
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 127, 1, 1));
        send_item(mk(0, 0, 0, 0, 0, 0, 0, -128, 1, 1));

        for (int ph = 0; ph < 8; ph++) begin
            tx_calm = (ph % 3 == 1);
            rx_calm = (ph % 4 == 2);
            case (ph)
                0: set_config(65, 65, 11520, 7680, 0);
                1: set_config(0, 0, 0, 0, 1);
                2: set_config(100, 100, 23040, 23040, 0);
                3: set_config(127, 101, 32767, 32767, 1);
                default: set_config($urandom_range(0, 127), $urandom_range(0, 127),
                                    $urandom_range(0, 32767), $urandom_range(0, 32767),
                                    $urandom_range(0, 1));
            endcase
            run_cells(200, ph == 4);
        end

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/occf_pkg.sv
rtl/core/occf_cfg.sv
rtl/core/occf_eval.sv
rtl/core/occupancy_cell_fusion_unit.sv
bench/occupancy_cell_fusion_checker.sv
bench/testbench.sv
